// ===== src/positional_list_store_defines.svh =====
// ----------------------------------------------------------------------------
// positional_list_store_defines
// Assertion macros used by the list store RTL.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pls_pkg.sv =====
// ----------------------------------------------------------------------------
// pls_pkg
// Types and codes for the positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_READ   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [4:0]  position;
    logic [31:0] item_in;
  } request_t;

  typedef struct packed {
    logic [31:0] item_out;
    logic [1:0]  status;
    logic [4:0]  count;
    logic        is_empty;
  } response_t;

  // Shift commands broadcast along the cell row.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

// ===== src/positional_list_store.sv =====
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered word list with insert, remove and read at a 1-based position.
// ----------------------------------------------------------------------------
// Usage:
//   request channel (in_valid/in_ready/request) carries action, position and
//   the word to insert; response channel (out_valid/out_ready/response)
//   returns one beat per request: the word removed or read, a status code,
//   the entry count after the operation and an empty flag.
//   cfg_we/cfg_wdata set the capacity; write it only while the block is idle.
// Response: the response beat is registered, valid in the cycle after its request beat.
// Throughput: one request per cycle while responses are taken. All slots shift in the same cycle in a
//   row of DEPTH cells, so inserts and removes cost no more than reads; the
//   single output register is the only hold point.
// Stall: while a response waits for out_ready, in_ready is low; a response
//   taken in the same cycle frees the register for the next request.
// Reset: count goes to zero, capacity to 16, the output register empties.
//   Slot contents are not cleared; slots past the count are never read.
// Errors (position out of range, insert on a full list) leave the list as is.
// ----------------------------------------------------------------------------
`include "positional_list_store_defines.svh"

module positional_list_store #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  pls_pkg::request_t   request,
  output logic                out_valid,
  input  logic                out_ready,
  output pls_pkg::response_t  response
);
  import pls_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > 5) ? CW : 5) + 1;

  logic [4:0]            capacity;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic                  in_fire;
  cell_ctl_t             ctl;
  cell_ctl_t             ctl_op;
  status_t               status_next;
  logic                  take_word;
  logic [CMPW-1:0]       cnt_w;
  logic [CMPW-1:0]       pos_w;
  logic                  pos_ok_rd;
  logic                  pos_ok_ins;
  logic                  full;
  logic [CW-1:0]         first;
  logic [WORD_WIDTH-1:0] word_in;
  logic [WORD_WIDTH-1:0] tap_or;
  logic [WORD_WIDTH-1:0] words [DEPTH];
  logic [WORD_WIDTH-1:0] taps  [DEPTH];
  logic [31:0]           item_next;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign cnt_w      = CMPW'(count);
  assign pos_w      = CMPW'(request.position);
  assign pos_ok_rd  = (request.position != 5'd0) && (pos_w <= cnt_w);
  assign pos_ok_ins = (request.position != 5'd0) && (pos_w <= cnt_w + 1'b1);
  assign full       = (cnt_w >= CMPW'(capacity)) || (cnt_w >= CMPW'(DEPTH));
  assign first      = CW'(request.position - 5'd1);
  assign word_in    = WORD_WIDTH'(request.item_in);

  always_comb begin
    ctl_op      = '0;
    status_next = ST_OK;
    count_next  = count;
    take_word   = 1'b0;
    case (request.action)
      ACT_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (!pos_ok_ins) begin
          status_next = ST_RANGE;
        end else begin
          ctl_op.ins = 1'b1;
          count_next = count + 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (!pos_ok_rd) begin
          status_next = ST_RANGE;
        end else begin
          ctl_op.rem = 1'b1;
          take_word  = 1'b1;
          count_next = count - 1'b1;
        end
      end
      ACT_READ: begin
        if (!pos_ok_rd) begin
          status_next = ST_RANGE;
        end else begin
          take_word = 1'b1;
        end
      end
      default: begin
        status_next = ST_RANGE;
      end
    endcase
  end

  assign ctl = in_fire ? ctl_op : '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_w;
    logic [WORD_WIDTH-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end
    pls_cell #(
      .CW         (CW),
      .WORD_WIDTH (WORD_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .first   (first),
      .last    (count),
      .word_in (word_in),
      .left    (left_w),
      .right   (right_w),
      .word    (words[i]),
      .tap     (taps[i])
    );
  end

  // only the addressed slot drives a nonzero tap
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tap_or = tap_or | taps[i];
    end
  end

  assign item_next = take_word ? 32'(tap_or) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= 5'd16;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (in_fire) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      response.item_out <= item_next;
      response.status   <= status_next;
      response.count    <= 5'(count_next);
      response.is_empty <= (count_next == '0);
    end
  end

  `PLS_ASSERT_NOW(a_count_bound, 1'b1, CMPW'(count) <= CMPW'(DEPTH), "count above depth")
  `PLS_ASSERT_NEXT(a_ins_grows, in_fire && ctl_op.ins, count == $past(count) + 1'b1, "insert did not grow count")
  `PLS_ASSERT_NEXT(a_err_keeps, in_fire && (status_next != ST_OK), $stable(count), "error changed count")
  `PLS_ASSERT_NEXT(a_resp_follows, in_fire, out_valid && (response.count == 5'(count)), "response count mismatch")

endmodule

// ===== src/pls_cell.sv =====
// ----------------------------------------------------------------------------
// pls_cell
// One list slot: holds a word, takes the inserted word or a neighbor's on a shift.
// ----------------------------------------------------------------------------
module pls_cell #(
  parameter int CW         = 5,
  parameter int WORD_WIDTH = 32,
  parameter int INDEX      = 0
) (
  input  logic                     clk,
  input  pls_pkg::cell_ctl_t       ctl,
  input  logic [CW-1:0]            first,
  input  logic [CW-1:0]            last,
  input  logic [WORD_WIDTH-1:0]    word_in,
  input  logic [WORD_WIDTH-1:0]    left,
  input  logic [WORD_WIDTH-1:0]    right,
  output logic [WORD_WIDTH-1:0]    word,
  output logic [WORD_WIDTH-1:0]    tap
);
  import pls_pkg::*;

  localparam logic [CW-1:0] IDX      = CW'(INDEX);
  localparam logic [CW-1:0] IDX_NEXT = CW'(INDEX + 1);

  logic hit;

  assign hit = (IDX == first);
  assign tap = hit ? word : '0;

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (hit) begin
        word <= word_in;
      end else if (IDX > first && IDX <= last) begin
        word <= left;
      end
    end else if (ctl.rem) begin
      // close the gap: slots from the removed one up to count-2 pull from above
      if (IDX >= first && IDX_NEXT < last) begin
        word <= right;
      end
    end
  end

endmodule
